// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the box blur block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define BB3_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BB3_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Field widths, register indexes and reset values of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

   // Widths of the request and response fields.
   localparam int SAMPLE_W  = 8;
   localparam int NUM_LANES = 4;
   localparam int ROW_W     = 16;
   localparam int COL_W     = 11;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int FWIDTH_W   = 12;
   localparam int NCH_W      = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } csr_index_type;

   // Register values after reset.
   localparam int RESET_WIDTH    = 640;
   localparam int RESET_HEIGHT   = 480;
   localparam int RESET_CHANNELS = 3;

   // Nine samples of at most 255 sum to at most 2295.
   localparam int SUM_W  = 12;
   localparam int RECIP_W = 13;
   localparam int PROD_W = SUM_W + RECIP_W;
   // floor(s / 9) == (s * 7282) >> 16 for every s below 4096.
   localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
   localparam int DIV9_SHIFT = 16;

endpackage

// ===== hdl/box_blur_3x3_border_copy.sv =====
// ----------------------------------------------------------------------------
// 3x3 box blur with border copy
// Streaming mean filter over a raster pixel stream of up to four channels.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one request per clock, and the block takes a
// new request in every cycle as long as the response side keeps up. Border
// pixels (first or last row or column) are returned unchanged; an interior
// pixel is returned once its lower-right neighbour has arrived, as the
// truncated mean of its 3x3 neighbourhood per channel. A pixel in row 2 or
// below and column 2 or beyond that also lies on the border produces two
// responses, the interior mean first and then the border copy, one after
// the other on the response port; every other request produces at most one
// response. Responses carry their own row and column and are therefore not in
// raster order. A request passes through stages 1, 2 and 3 and the response
// buffer. The two previous rows live in one line memory of MAX_WIDTH words,
// each holding two packed pixels, read when a request is taken and written
// when the pixel leaves stage 1; a 3x3 window of registers feeds the adder
// tree, and the divide by nine is a constant multiply one stage further on.
// The memory needs no clearing after reset because a mean is only formed
// from rows of the current frame. Writing any configuration register
// restarts the frame at row 0, column 0; configure only while the block is
// idle. Lanes at or above the channel count read as zero.
module box_blur_3x3_border_copy
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_in_0,
   input  logic [SAMPLE_W-1:0]   req_in_1,
   input  logic [SAMPLE_W-1:0]   req_in_2,
   input  logic [SAMPLE_W-1:0]   req_in_3,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROW_W-1:0]      rsp_pixel_row,
   output logic [COL_W-1:0]      rsp_pixel_col,
   output logic [SAMPLE_W-1:0]   rsp_out_0,
   output logic [SAMPLE_W-1:0]   rsp_out_1,
   output logic [SAMPLE_W-1:0]   rsp_out_2,
   output logic [SAMPLE_W-1:0]   rsp_out_3,
   output logic                  rsp_run_last,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int PIX_W = SAMPLE_W * MAX_CHANNELS;

   localparam int RESET_COLS = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int RESET_NCH  = (RESET_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS
                                                               : RESET_CHANNELS;
   localparam logic [CW-1:0]    RESET_LAST_COL = CW'(RESET_COLS - 1);
   localparam logic [ROW_W-1:0] RESET_LAST_ROW = ROW_W'(RESET_HEIGHT - 1);
   localparam logic [NCH_W-1:0] RESET_NCH_VAL  = NCH_W'(RESET_NCH);

   typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] pix_type;
   typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0]    lanes_type;
   typedef logic [MAX_CHANNELS-1:0][SUM_W-1:0]    sums_type;

   // ------------------------------------------------------------------------
   // Configuration. The registers are kept in their effective form: index of
   // the last column, index of the last row and the clamped channel count.
   // ------------------------------------------------------------------------
   logic [CW-1:0]    last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   logic [NCH_W-1:0] nch_ff, nch_in;
   logic             csr_write;
   logic             csr_hit;

   logic [FWIDTH_W-1:0]   cfg_width;
   logic [CSR_DATA_W-1:0] cfg_height;
   logic [NCH_W-1:0]      cfg_nch;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign cfg_width  = csr_data[FWIDTH_W-1:0];
   assign cfg_height = csr_data;
   assign cfg_nch    = csr_data[NCH_W-1:0];

   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      nch_in      = nch_ff;
      csr_hit     = 1'b0;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               csr_hit = 1'b1;
               if (cfg_width == '0) begin
                  last_col_in = '0;
               end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
                  last_col_in = CW'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = CW'(cfg_width - 1'b1);
               end
            end
            CSR_FRAME_HEIGHT: begin
               csr_hit = 1'b1;
               last_row_in = (cfg_height == '0) ? '0 : ROW_W'(cfg_height - 1'b1);
            end
            CSR_CHANNEL_COUNT: begin
               csr_hit = 1'b1;
               if (cfg_nch == '0) begin
                  nch_in = NCH_W'(1);
               end else if (32'(cfg_nch) > 32'(MAX_CHANNELS)) begin
                  nch_in = NCH_W'(MAX_CHANNELS);
               end else begin
                  nch_in = cfg_nch;
               end
            end
            default: begin
               // An index beyond the register list is ignored altogether.
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= RESET_LAST_COL;
         last_row_ff <= RESET_LAST_ROW;
         nch_ff      <= RESET_NCH_VAL;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         nch_ff      <= nch_in;
      end
   end

   // ------------------------------------------------------------------------
   // Flow control. Each stage loads when it is empty or its contents move on,
   // so bubbles close up and requests keep coming while a response waits.
   // ------------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff;
   logic out_int_pend_ff, out_brd_pend_ff;
   logic rsp_take, out_ld_ok;
   logic s3_mv, s3_ld_ok;
   logic s2_has, s2_mv, s2_ld_ok;
   logic s1_mv, s1_ld_ok;
   logic req_take;

   assign rsp_valid = out_int_pend_ff || out_brd_pend_ff;
   assign rsp_take  = rsp_valid && !rsp_stall;
   // The buffer is free next cycle if it is empty, or if the response taken
   // now is the only one it still holds.
   assign out_ld_ok = !rsp_valid || (rsp_take && !(out_int_pend_ff && out_brd_pend_ff));

   assign s3_mv    = s3_v_ff && out_ld_ok;
   assign s3_ld_ok = !s3_v_ff || s3_mv;
   // A pixel that completes nothing drops out after the window stage.
   assign s2_mv    = s2_v_ff && (s3_ld_ok || !s2_has);
   assign s2_ld_ok = !s2_v_ff || s2_mv;
   assign s1_mv    = s1_v_ff && s2_ld_ok;
   assign s1_ld_ok = !s1_v_ff || s1_mv;

   assign req_stall = !s1_ld_ok;
   assign req_take  = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // Position of the next incoming pixel.
   // ------------------------------------------------------------------------
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_take) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: the request is registered while the line memory is read at its
   // column. Each memory word holds the previous row's pixel (upper half) and
   // the pixel of the row before that (lower half).
   // ------------------------------------------------------------------------
   lanes_type req_lane;
   pix_type   req_pix;
   pix_type   s1_pix_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_int_ff, s1_brd_ff;
   logic [2*PIX_W-1:0] line_rd;
   pix_type   line_mid, line_top;

   assign req_lane = {req_in_3, req_in_2, req_in_1, req_in_0};

   for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_req_pix
      assign req_pix[k] = (NCH_W'(k) < nch_ff) ? req_lane[k] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ld_ok) begin
         s1_v_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pix_ff <= req_pix;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         // A mean for the pixel above-left is complete from row 2, column 2.
         s1_int_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2));
         s1_brd_ff <= (row_ff == '0) || (col_ff == '0) ||
                      (row_ff == last_row_ff) || (col_ff == last_col_ff);
      end
   end

   // Reads and writes in the same cycle hit different columns whenever the
   // frame is wide enough for a mean to be formed at all.
   bb3_ram #(
      .WIDTH (2*PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_mv),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_pix_ff, line_mid}),
      .rd_en   (req_take),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign line_mid = line_rd[2*PIX_W-1:PIX_W];
   assign line_top = line_rd[PIX_W-1:0];

   // ------------------------------------------------------------------------
   // Stage 2: the 3x3 window shifts left as the pixel moves on, then its
   // nine samples are summed per channel.
   // ------------------------------------------------------------------------
   pix_type win_ff [9];
   pix_type s2_pix_ff;
   logic [CW-1:0]    s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic             s2_int_ff, s2_brd_ff;
   sums_type         win_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_ld_ok) begin
         s2_v_ff <= s1_mv;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_mv) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i*3]   <= win_ff[i*3+1];
            win_ff[i*3+1] <= win_ff[i*3+2];
         end
         win_ff[2] <= line_top;
         win_ff[5] <= line_mid;
         win_ff[8] <= s1_pix_ff;
         s2_pix_ff <= s1_pix_ff;
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
         s2_int_ff <= s1_int_ff;
         s2_brd_ff <= s1_brd_ff;
      end
   end

   assign s2_has = s2_int_ff || s2_brd_ff;

   always_comb begin
      logic [SUM_W-1:0] row_sum [3];
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         for (int i = 0; i < 3; i++) begin
            row_sum[i] = SUM_W'(win_ff[i*3][k]) + SUM_W'(win_ff[i*3+1][k]) +
                         SUM_W'(win_ff[i*3+2][k]);
         end
         win_sum[k] = row_sum[0] + row_sum[1] + row_sum[2];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: sums and the border copy wait here; the divide by nine is done
   // on the way into the response buffer.
   // ------------------------------------------------------------------------
   sums_type         s3_sum_ff;
   pix_type          s3_pix_ff;
   logic [CW-1:0]    s3_col_ff;
   logic [ROW_W-1:0] s3_row_ff;
   logic             s3_int_ff, s3_brd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_ld_ok) begin
         s3_v_ff <= s2_mv && s2_has;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ld_ok) begin
         s3_sum_ff <= win_sum;
         s3_pix_ff <= s2_pix_ff;
         s3_col_ff <= s2_col_ff;
         s3_row_ff <= s2_row_ff;
         s3_int_ff <= s2_int_ff;
         s3_brd_ff <= s2_brd_ff;
      end
   end

   lanes_type        mean_lane, copy_lane;
   logic [CW-1:0]    s3_col_m1;

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      if (k < MAX_CHANNELS) begin : g_used
         logic [PROD_W-1:0] prod;
         assign prod = PROD_W'(s3_sum_ff[k]) * PROD_W'(DIV9_RECIP);
         assign mean_lane[k] = (NCH_W'(k) < nch_ff) ?
                               prod[DIV9_SHIFT +: SAMPLE_W] : '0;
         assign copy_lane[k] = s3_pix_ff[k];
      end else begin : g_unused
         assign mean_lane[k] = '0;
         assign copy_lane[k] = '0;
      end
   end

   assign s3_col_m1 = s3_col_ff - 1'b1;

   // ------------------------------------------------------------------------
   // Response buffer: one slot for the interior mean, one for the border
   // copy. The mean goes out first when both are pending.
   // ------------------------------------------------------------------------
   logic [ROW_W-1:0] out_int_row_ff, out_brd_row_ff;
   logic [COL_W-1:0] out_int_col_ff, out_brd_col_ff;
   lanes_type        out_int_lane_ff, out_brd_lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_int_pend_ff <= 1'b0;
         out_brd_pend_ff <= 1'b0;
      end else if (s3_mv) begin
         out_int_pend_ff <= s3_int_ff;
         out_brd_pend_ff <= s3_brd_ff;
      end else if (rsp_take) begin
         if (out_int_pend_ff) begin
            out_int_pend_ff <= 1'b0;
         end else begin
            out_brd_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_mv) begin
         out_int_row_ff  <= s3_row_ff - 1'b1;
         out_int_col_ff  <= COL_W'(s3_col_m1);
         out_int_lane_ff <= mean_lane;
         out_brd_row_ff  <= s3_row_ff;
         out_brd_col_ff  <= COL_W'(s3_col_ff);
         out_brd_lane_ff <= copy_lane;
      end
   end

   lanes_type rsp_lane;

   assign rsp_pixel_row = out_int_pend_ff ? out_int_row_ff  : out_brd_row_ff;
   assign rsp_pixel_col = out_int_pend_ff ? out_int_col_ff  : out_brd_col_ff;
   assign rsp_lane      = out_int_pend_ff ? out_int_lane_ff : out_brd_lane_ff;
   assign rsp_run_last  = !(out_int_pend_ff && out_brd_pend_ff);

   assign rsp_out_0 = rsp_lane[0];
   assign rsp_out_1 = rsp_lane[1];
   assign rsp_out_2 = rsp_lane[2];
   assign rsp_out_3 = rsp_lane[3];

endmodule

// ===== hdl/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bb3_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// Box blur checker
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bb3_checker
   import bb3_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [ROW_W-1:0]    rsp_pixel_row,
   input logic [COL_W-1:0]    rsp_pixel_col,
   input logic [SAMPLE_W-1:0] rsp_out_0,
   input logic                rsp_run_last
);

   // Nothing is offered in the cycle after reset.
   `BB3_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "response after reset")

   // A stalled response keeps its valid and its position.
   `BB3_ASSERT(a_hold_valid, rsp_valid && rsp_stall |=> rsp_valid, "valid dropped under stall")
   `BB3_ASSERT(a_hold_pos, rsp_valid && rsp_stall |=> $stable(rsp_pixel_row) && $stable(rsp_pixel_col) && $stable(rsp_out_0), "response changed under stall")

   // A mean that is not the last response of its pixel is followed at once by
   // the border copy of the pixel below-right of it.
   `BB3_ASSERT(a_pair_follows, rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid, "second response missing")
   `BB3_ASSERT(a_pair_position, rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_pixel_row == $past(rsp_pixel_row) + 16'd1 && rsp_pixel_col == $past(rsp_pixel_col) + 11'd1, "border copy not below-right of its mean")

endmodule

bind box_blur_3x3_border_copy bb3_checker u_bb3_checker (.*);
